>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LFU_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LFU_ASSERT(lbl, prop, msg) \
  `LFU_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`else

`define LFU_ASSERT_AT(lbl, clk, rst_n, prop, msg)

`define LFU_ASSERT(lbl, prop, msg)

`endif

`endif

>>> rtl/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [WORD_W-1:0] WORD_MAX  = '1;
  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] uses;
    logic [WORD_W-1:0] touched;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
  } sts_t;

endpackage

>>> rtl/lfu_cache_replacement.sv
`timescale 1ns / 1ps
// channel    direction  handshake                 payload
// item       in         start && !busy            opcode_i, lookup_key_i, write_value_i
// result     out        done_o, one cycle         found_o, read_value_o, evicted_o, evicted_key_o
// capacity   in         capacity_we_i             capacity_i
//
// an item runs from accept through one memory read per entry for the key and victim scan,
// a drain state that settles the last read and one commit, then back to the idle state in
// which the next item is taken
// the result strobe done_o comes in the cycle after the commit, when busy is already low
// after reset a clearing pass writes every entry empty with busy high
// the receiver cannot stall; done_o marks the result for one cycle, the outputs hold until the next commit
`include "assert_macros.svh"

module lfu_cache_replacement #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode_i,
  input  logic [lfu_pkg::WORD_W-1:0] lookup_key_i,
  input  logic [lfu_pkg::WORD_W-1:0] write_value_i,
  input  logic                       capacity_we_i,
  input  logic [lfu_pkg::CAP_W-1:0]  capacity_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [lfu_pkg::WORD_W-1:0] read_value_o,
  output logic                       evicted_o,
  output logic [lfu_pkg::WORD_W-1:0] evicted_key_o
);

  lfu_pkg::cmd_t cmd;
  lfu_pkg::sts_t sts;

  lfu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  lfu_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .lookup_key_i (lookup_key_i),
    .write_value_i(write_value_i),
    .capacity_we_i(capacity_we_i),
    .capacity_i   (capacity_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o)
  );

  `LFU_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `LFU_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  `LFU_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `LFU_ASSERT(a_evict_miss, (done_o && evicted_o) |-> !found_o, "eviction on a key hit")

endmodule

>>> rtl/lfu_datapath.sv
`timescale 1ns / 1ps

module lfu_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lfu_pkg::cmd_t              cmd_i,
  output lfu_pkg::sts_t              sts_o,
  input  logic                       opcode_i,
  input  logic [lfu_pkg::WORD_W-1:0] lookup_key_i,
  input  logic [lfu_pkg::WORD_W-1:0] write_value_i,
  input  logic                       capacity_we_i,
  input  logic [lfu_pkg::CAP_W-1:0]  capacity_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [lfu_pkg::WORD_W-1:0] read_value_o,
  output logic                       evicted_o,
  output logic [lfu_pkg::WORD_W-1:0] evicted_key_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

  lfu_pkg::entry_t mem [CAPACITY];
  lfu_pkg::entry_t rdata_q;
  lfu_pkg::entry_t mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;

  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] ridx_q;
  logic             rvalid_q;

  logic                       op_q;
  logic [lfu_pkg::WORD_W-1:0] key_q;
  logic [lfu_pkg::WORD_W-1:0] val_q;

  logic                       found_q;
  logic [IDX_W-1:0]           hit_idx_q;
  logic [lfu_pkg::WORD_W-1:0] hit_val_q;
  logic [lfu_pkg::WORD_W-1:0] hit_uses_q;

  logic                       have_vic_q;
  logic [IDX_W-1:0]           vic_idx_q;
  logic [lfu_pkg::WORD_W-1:0] vic_key_q;
  logic [lfu_pkg::WORD_W-1:0] vic_uses_q;
  logic [lfu_pkg::WORD_W-1:0] vic_touch_q;

  logic             have_free_q;
  logic [IDX_W-1:0] free_idx_q;

  logic [OCC_W-1:0]           occ_q;
  logic [lfu_pkg::WORD_W-1:0] tclk_q;
  logic [lfu_pkg::CAP_W-1:0]  cap_q;

  logic                       done_q;
  logic                       found_out_q;
  logic [lfu_pkg::WORD_W-1:0] rd_out_q;
  logic                       ev_out_q;
  logic [lfu_pkg::WORD_W-1:0] evk_out_q;

  logic hit_now;
  logic vic_now;
  logic free_now;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] limit;
  logic             put_ok;
  logic             upd_hit;
  logic             miss_put;
  logic             ev;
  logic             ins;
  logic [IDX_W-1:0] slot;
  logic [lfu_pkg::WORD_W-1:0] tclk_next;
  logic [lfu_pkg::WORD_W-1:0] hit_uses_next;

  assign sts_o.idx_last = (idx_q == IDX_LAST);

  // scan evaluation of the entry read in the previous cycle
  assign hit_now  = rvalid_q && rdata_q.valid && !found_q && (rdata_q.key == key_q);
  assign vic_now  = rvalid_q && rdata_q.valid &&
                    (!have_vic_q || (rdata_q.uses < vic_uses_q) ||
                     ((rdata_q.uses == vic_uses_q) && (rdata_q.touched < vic_touch_q)));
  assign free_now = rvalid_q && !rdata_q.valid && !have_free_q;

  // commit decision
  assign cap_ext  = CMP_W'(cap_q);
  assign limit    = (cap_ext < CMP_W'(CAPACITY)) ? cap_ext : CMP_W'(CAPACITY);
  assign put_ok   = (op_q == lfu_pkg::OP_PUT) && (limit != '0);
  assign upd_hit  = found_q && ((op_q == lfu_pkg::OP_GET) || put_ok);
  assign miss_put = put_ok && !found_q;
  assign ev       = miss_put && ((CMP_W'(occ_q) >= limit) || !have_free_q) && have_vic_q;
  assign ins      = miss_put && (ev || have_free_q);
  assign slot     = ev ? vic_idx_q : free_idx_q;

  assign tclk_next     = (tclk_q == lfu_pkg::WORD_MAX) ? tclk_q : tclk_q + 1'b1;
  assign hit_uses_next = (hit_uses_q == lfu_pkg::WORD_MAX) ? hit_uses_q : hit_uses_q + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.commit && upd_hit) begin
      mem_we            = 1'b1;
      mem_waddr         = hit_idx_q;
      mem_wdata.valid   = 1'b1;
      mem_wdata.key     = key_q;
      mem_wdata.value   = (op_q == lfu_pkg::OP_PUT) ? val_q : hit_val_q;
      mem_wdata.uses    = hit_uses_next;
      mem_wdata.touched = tclk_q;
    end else if (cmd_i.commit && ins) begin
      mem_we            = 1'b1;
      mem_waddr         = slot;
      mem_wdata.valid   = 1'b1;
      mem_wdata.key     = key_q;
      mem_wdata.value   = val_q;
      mem_wdata.uses    = lfu_pkg::WORD_W'(1);
      mem_wdata.touched = tclk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ridx_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.scan;
      // index of the entry now in rdata_q
      ridx_q   <= idx_q;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.clear || cmd_i.scan) begin
        idx_q <= sts_o.idx_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= lookup_key_i;
      val_q <= write_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      have_vic_q  <= 1'b0;
      have_free_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q     <= 1'b0;
      have_vic_q  <= 1'b0;
      have_free_q <= 1'b0;
    end else begin
      if (hit_now) found_q <= 1'b1;
      if (vic_now) have_vic_q <= 1'b1;
      if (free_now) have_free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_now) begin
      hit_idx_q  <= ridx_q;
      hit_val_q  <= rdata_q.value;
      hit_uses_q <= rdata_q.uses;
    end
    if (vic_now) begin
      vic_idx_q   <= ridx_q;
      vic_key_q   <= rdata_q.key;
      vic_uses_q  <= rdata_q.uses;
      vic_touch_q <= rdata_q.touched;
    end
    if (free_now) begin
      free_idx_q <= ridx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      tclk_q <= '0;
      cap_q  <= lfu_pkg::CAP_RESET;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (capacity_we_i) begin
        cap_q <= capacity_i;
      end
      if (cmd_i.commit) begin
        if (upd_hit || ins) begin
          tclk_q <= tclk_next;
        end
        // an eviction frees the slot it refills, so occupancy only grows on a plain insert
        if (ins && !ev) begin
          occ_q <= occ_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      found_out_q <= found_q;
      rd_out_q    <= ((op_q == lfu_pkg::OP_GET) && found_q) ? hit_val_q : '0;
      ev_out_q    <= ev;
      evk_out_q   <= ev ? vic_key_q : '0;
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_out_q;
  assign read_value_o  = rd_out_q;
  assign evicted_o     = ev_out_q;
  assign evicted_key_o = evk_out_q;

endmodule

>>> rtl/lfu_ctrl.sv
`timescale 1ns / 1ps

module lfu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  lfu_pkg::sts_t sts_i,
  output lfu_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.idx_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.idx_last) state_d = ST_DRAIN;
      end
      // last read entry is evaluated here
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
